// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define C5FS_ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define C5FS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/c5fs_pkg.sv
package c5fs_pkg;

    // fixed formats
    localparam int DATA_W    = 16;
    localparam int KERNEL    = 5;
    localparam int TAPS      = KERNEL * KERNEL;
    localparam int LINES     = KERNEL - 1;
    localparam int SLOT_W    = $clog2(LINES);
    localparam int IDX_W     = 5;
    localparam int QSHIFT    = 8;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TERM_W    = PROD_W - QSHIFT;
    localparam int SUM_W     = TERM_W + $clog2(TAPS);
    localparam int CONV_W    = 28;
    localparam int POS_W     = 5;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // defaults and sizes
    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam logic [CFG_W-1:0] CFG_WIDTH_RESET  = 6'd28;
    localparam logic [CFG_W-1:0] CFG_HEIGHT_RESET = 6'd28;

    typedef enum logic {
        ACT_WEIGHT = 1'b0,
        ACT_PIXEL  = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                     action;
        logic [IDX_W-1:0]         weight_index;
        logic signed [DATA_W-1:0] weight_value;
        logic signed [DATA_W-1:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic signed [CONV_W-1:0] conv_sum;
        logic [POS_W-1:0]         out_row;
        logic [POS_W-1:0]         out_col;
        logic                     last_of_frame;
    } t_out_item;

    // classified item passed from front to back
    typedef struct packed {
        t_action                        kind;
        logic [IDX_W-1:0]               widx;
        logic signed [DATA_W-1:0]       wval;
        logic signed [DATA_W-1:0]       px;
        logic [LINES-1:0][DATA_W-1:0]   col_data;
        logic                           emit;
        logic [POS_W-1:0]               row;
        logic [POS_W-1:0]               col;
        logic                           last;
    } t_q_entry;

    // result position carried down the back pipeline
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_meta;

    // product / 256 toward zero, one less when the product is negative
    function automatic logic signed [TERM_W-1:0] scale_term(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] q;
        q = p[PROD_W-1] ? (p - PROD_W'(1)) : p;
        return q[PROD_W-1:QSHIFT];
    endfunction

endpackage

// File: sv/c5fs_queue.sv
module c5fs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  c5fs_pkg::t_q_entry  i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output c5fs_pkg::t_q_entry  o_entry
);

    localparam int DEPTH = c5fs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    c5fs_pkg::t_q_entry r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/c5fs_front.sv
module c5fs_front #(
    parameter int MAX_WIDTH  = c5fs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c5fs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  c5fs_pkg::t_in_item                  i_in_data,
    input  logic                                i_cfg_we,
    input  logic [c5fs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [c5fs_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_push,
    output c5fs_pkg::t_q_entry                  o_entry,
    input  logic                                i_q_full
);

    localparam int WD_W   = $clog2(MAX_WIDTH + 1);
    localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
    localparam int CC_W   = $clog2(MAX_WIDTH);
    localparam int RC_W   = $clog2(MAX_HEIGHT);
    localparam int DW     = c5fs_pkg::DATA_W;
    localparam int LINES  = c5fs_pkg::LINES;
    localparam int SLOT_W = c5fs_pkg::SLOT_W;
    localparam int POS_W  = c5fs_pkg::POS_W;
    localparam int KM1    = c5fs_pkg::KERNEL - 1;

    logic [c5fs_pkg::CFG_W-1:0] r_cfg_w;
    logic [c5fs_pkg::CFG_W-1:0] r_cfg_h;
    logic [CC_W-1:0]            r_col;
    logic [RC_W-1:0]            r_row;
    logic                       r_f1_valid;
    c5fs_pkg::t_q_entry         r_f1;
    logic [SLOT_W-1:0]          r_slot;
    logic signed [DW-1:0]       r_line_mem [LINES][MAX_WIDTH];
    logic signed [DW-1:0]       r_rd [LINES];

    logic [WD_W-1:0]            w_eff;
    logic [HD_W-1:0]            h_eff;
    logic [WD_W-1:0]            col_e;
    logic [HD_W-1:0]            row_e;
    logic [WD_W-1:0]            col_n;
    logic [HD_W-1:0]            row_n;
    logic                       accept;
    logic                       is_pix;
    logic                       keep;
    logic [CC_W-1:0]            col_idx;
    logic [SLOT_W-1:0]          row_slot;
    c5fs_pkg::t_q_entry         n_f1;

    // handshake
    assign o_push     = r_f1_valid && !i_q_full;
    assign o_in_ready = !r_f1_valid || !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_pix     = (i_in_data.action == c5fs_pkg::ACT_PIXEL);
    assign keep       = is_pix ||
                        (i_in_data.weight_index < c5fs_pkg::IDX_W'(c5fs_pkg::TAPS));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= c5fs_pkg::CFG_WIDTH_RESET;
            r_cfg_h <= c5fs_pkg::CFG_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (c5fs_pkg::t_cfg_idx'(i_cfg_idx))
                c5fs_pkg::CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                c5fs_pkg::CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size: zero acts as one, saturate at the maximum
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WD_W'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = WD_W'(MAX_WIDTH);
        end else begin
            w_eff = WD_W'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HD_W'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h_eff = HD_W'(MAX_HEIGHT);
        end else begin
            h_eff = HD_W'(r_cfg_h);
        end
    end

    // position of this pixel and of the next one
    always_comb begin
        col_e = WD_W'(r_col);
        row_e = HD_W'(r_row);
        if (col_e >= w_eff) begin
            col_e = '0;
            row_e = row_e + HD_W'(1);
        end
        if (row_e >= h_eff) begin
            row_e = '0;
        end
        col_n = col_e + WD_W'(1);
        row_n = row_e;
        if (col_n >= w_eff) begin
            col_n = '0;
            row_n = row_e + HD_W'(1);
            if (row_n >= h_eff) begin
                row_n = '0;
            end
        end
    end

    assign col_idx  = CC_W'(col_e);
    assign row_slot = row_e[SLOT_W-1:0];

    // classify the incoming item
    always_comb begin
        n_f1          = '0;
        n_f1.kind     = is_pix ? c5fs_pkg::ACT_PIXEL : c5fs_pkg::ACT_WEIGHT;
        n_f1.widx     = i_in_data.weight_index;
        n_f1.wval     = i_in_data.weight_value;
        n_f1.px       = i_in_data.pixel;
        n_f1.emit     = (row_e >= HD_W'(KM1)) && (col_e >= WD_W'(KM1));
        n_f1.row      = POS_W'(row_e - HD_W'(KM1));
        n_f1.col      = POS_W'(col_e - WD_W'(KM1));
        n_f1.last     = ((col_e + WD_W'(1)) == w_eff) && ((row_e + HD_W'(1)) == h_eff);
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept && is_pix) begin
            r_col <= CC_W'(col_n);
            r_row <= RC_W'(row_n);
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (accept) begin
            r_f1_valid <= keep;
        end else if (o_push) begin
            r_f1_valid <= 1'b0;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1   <= n_f1;
            r_slot <= row_slot;
        end
    end

    // line buffer: one lane per buffered row, read old column then overwrite own lane
    always_ff @(posedge i_clk) begin
        if (accept && is_pix) begin
            for (int k = 0; k < LINES; k++) begin
                r_rd[k] <= r_line_mem[k][col_idx];
                if (SLOT_W'(k) == row_slot) begin
                    r_line_mem[k][col_idx] <= i_in_data.pixel;
                end
            end
        end
    end

    // order the buffered column oldest row first
    always_comb begin
        o_entry = r_f1;
        for (int k = 0; k < LINES; k++) begin
            o_entry.col_data[k] = r_rd[SLOT_W'(r_slot + SLOT_W'(k))];
        end
    end

endmodule

// File: sv/c5fs_back.sv
module c5fs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_entry_valid,
    input  c5fs_pkg::t_q_entry  i_entry,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output c5fs_pkg::t_out_item o_out_data
);

    localparam int K      = c5fs_pkg::KERNEL;
    localparam int TAPS   = c5fs_pkg::TAPS;
    localparam int LINES  = c5fs_pkg::LINES;
    localparam int DW     = c5fs_pkg::DATA_W;
    localparam int PROD_W = c5fs_pkg::PROD_W;
    localparam int TERM_W = c5fs_pkg::TERM_W;
    localparam int SUM_W  = c5fs_pkg::SUM_W;

    logic signed [DW-1:0]     r_wgt [TAPS];
    logic signed [DW-1:0]     r_win [K][K];
    logic signed [PROD_W-1:0] r_prod [TAPS];
    logic signed [TERM_W-1:0] r_term [TAPS];
    logic signed [SUM_W-1:0]  r_rsum [K];
    logic                     r_s1_v;
    logic                     r_s2_v;
    logic                     r_s3_v;
    logic                     r_s4_v;
    c5fs_pkg::t_meta          r_m1;
    c5fs_pkg::t_meta          r_m2;
    c5fs_pkg::t_meta          r_m3;
    c5fs_pkg::t_meta          r_m4;
    logic                     r_out_valid;
    c5fs_pkg::t_out_item      r_out;

    logic                     adv;
    logic                     pop_pix;
    logic signed [SUM_W-1:0]  total;

    // whole pipeline moves when the output register can take a result
    assign adv         = !r_out_valid || i_out_ready;
    assign o_pop       = i_entry_valid && adv;
    assign pop_pix     = o_pop && (i_entry.kind == c5fs_pkg::ACT_PIXEL);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // weight writes and window shift, in item order
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_entry.kind == c5fs_pkg::ACT_WEIGHT) begin
                r_wgt[i_entry.widx] <= i_entry.wval;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < K; k++) begin
                for (int l = 0; l < K; l++) begin
                    r_win[k][l] <= '0;
                end
            end
        end else if (pop_pix) begin
            for (int k = 0; k < K; k++) begin
                for (int l = 0; l < K - 1; l++) begin
                    r_win[k][l] <= r_win[k][l + 1];
                end
            end
            for (int k = 0; k < LINES; k++) begin
                r_win[k][K - 1] <= $signed(i_entry.col_data[k]);
            end
            r_win[K - 1][K - 1] <= i_entry.px;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_v      <= pop_pix && i_entry.emit;
            r_s2_v      <= r_s1_v;
            r_s3_v      <= r_s2_v;
            r_s4_v      <= r_s3_v;
            r_out_valid <= r_s4_v;
        end
    end

    // final adder of the row sums
    always_comb begin
        total = '0;
        for (int k = 0; k < K; k++) begin
            total = total + r_rsum[k];
        end
    end

    // products, scaled terms, row sums, total
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1 <= '{row: i_entry.row, col: i_entry.col, last: i_entry.last};
            r_m2 <= r_m1;
            r_m3 <= r_m2;
            r_m4 <= r_m3;
            for (int k = 0; k < K; k++) begin
                for (int l = 0; l < K; l++) begin
                    r_prod[k * K + l] <= PROD_W'(r_win[k][l]) * PROD_W'(r_wgt[k * K + l]);
                end
            end
            for (int i = 0; i < TAPS; i++) begin
                r_term[i] <= c5fs_pkg::scale_term(r_prod[i]);
            end
            for (int k = 0; k < K; k++) begin
                r_rsum[k] <= SUM_W'(r_term[k * K]) + SUM_W'(r_term[k * K + 1])
                           + SUM_W'(r_term[k * K + 2]) + SUM_W'(r_term[k * K + 3])
                           + SUM_W'(r_term[k * K + 4]);
            end
            r_out.conv_sum      <= c5fs_pkg::CONV_W'(total);
            r_out.out_row       <= r_m4.row;
            r_out.out_col       <= r_m4.col;
            r_out.last_of_frame <= r_m4.last;
        end
    end

endmodule

// File: sv/conv5x5_fixed_point_stream_top.sv
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_in_data  (weight load or pixel)
// output    out        o_out_valid / i_out_ready  o_out_data (one window sum)
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while results are taken; a pixel that closes a window shows its result
// after the front stage, 4-entry queue, 4 back stages and output register
// synchronous active-low reset clears counters, window and pipeline; stores are not cleared
// front stalls only when the queue is full, back stalls only on the output register
module conv5x5_fixed_point_stream_top #(
    parameter int MAX_WIDTH  = c5fs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c5fs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  c5fs_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output c5fs_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [c5fs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [c5fs_pkg::CFG_W-1:0]      i_cfg_data
);

    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               pop;
    c5fs_pkg::t_q_entry f_entry;
    c5fs_pkg::t_q_entry q_entry;

    // front: classify, track position, line buffer
    c5fs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_entry    (f_entry),
        .i_q_full   (q_full)
    );

    // decoupling queue
    c5fs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // back: weights, window, multiply and sum
    c5fs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (q_valid),
        .i_entry       (q_entry),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

endmodule

// File: sv/c5fs_checker.sv
`include "assert_macros.svh"

module c5fs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input c5fs_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input c5fs_pkg::t_out_item o_out_data
);

    logic r_seen_pix;

    // remember whether any pixel went in since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_pix <= 1'b0;
        end else if (i_in_valid && o_in_ready &&
                     (i_in_data.action == c5fs_pkg::ACT_PIXEL)) begin
            r_seen_pix <= 1'b1;
        end
    end

    `C5FS_ASSERT_ALWAYS(a_rst_no_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `C5FS_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> o_in_ready, "input not ready after reset")
    `C5FS_ASSERT_SYNC(a_out_needs_pix, i_clk, i_rst_n, o_out_valid |-> r_seen_pix, "result without pixel")
    `C5FS_ASSERT_SYNC(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped")
    `C5FS_ASSERT_SYNC(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_data), "result changed in stall")

endmodule

bind conv5x5_fixed_point_stream_top c5fs_checker u_c5fs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
